@@ rtl/vrts_pkg.sv @@
// shared types and constants of the voxel ray traversal step unit
package vrts_pkg;

    localparam int GRID_BITS = 11;
    localparam logic [GRID_BITS-1:0] GRID_RESET = 11'd1024;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [1:0] {
        ACT_SET_END = 2'd0,
        ACT_START   = 2'd1,
        ACT_STEP    = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GRID_X     = 2'd0,
        CFG_GRID_Y     = 2'd1,
        CFG_GRID_Z     = 2'd2,
        CFG_KEEP_FIRST = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // index is {x<y, x<z, y<z}
    localparam axis_t AXIS_PICK [8] = '{
        AXIS_Z, AXIS_Y, AXIS_Z, AXIS_Y, AXIS_Z, AXIS_Z, AXIS_X, AXIS_X
    };

    typedef struct packed {
        logic cell_valid;
        logic ray_done;
    } res_flags_t;

endpackage

@@ rtl/vrts_axis_sel.sv @@
// picks the axis with the nearest boundary crossing
module vrts_axis_sel #(
    parameter int TB = 32
) (
    input  logic [2:0][TB-1:0] tnext,
    output vrts_pkg::axis_t    axis
);
    import vrts_pkg::*;

    logic [2:0] sel;

    always_comb
    begin
        sel[2] = tnext[0] < tnext[1];
        sel[1] = tnext[0] < tnext[2];
        sel[0] = tnext[1] < tnext[2];
        axis   = AXIS_PICK[sel];
    end

endmodule

@@ rtl/vrts_core.sv @@
// traversal state and the single-pass step datapath
module vrts_core #(
    parameter int CB = 10,
    parameter int TB = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 fire,
    input  logic [1:0]                           act,
    input  logic [2:0][CB-1:0]                   cell_in,
    input  logic [2:0]                           signs_in,
    input  logic [2:0][TB-1:0]                   tmax,
    input  logic [2:0][TB-1:0]                   tdelta,
    input  logic                                 use_end,
    input  logic [2:0][vrts_pkg::GRID_BITS-1:0]  grid,
    input  logic                                 keep_first,
    output logic [2:0][CB-1:0]                   res_cell,
    output vrts_pkg::res_flags_t                 res_flags
);
    import vrts_pkg::*;

    localparam int PW = CB + 1;
    localparam int UW = (GRID_BITS > PW) ? GRID_BITS : PW;
    localparam logic [UW-1:0] SPAN = UW'(1) << CB;

    logic [2:0][PW-1:0] pos_reg, pos_next;
    logic [2:0][TB-1:0] tnext_reg, tnext_next;
    logic [2:0][TB-1:0] tstep_reg, tstep_next;
    logic [2:0]         signs_reg, signs_next;
    logic [2:0][CB-1:0] end_reg, end_next;
    logic               end_en_reg, end_en_next;
    logic               active_reg, active_next;

    axis_t              axis;
    logic [2:0][UW-1:0] lim;
    logic [2:0][PW-1:0] pos_stp;
    logic [2:0]         off;
    logic [2:0]         end_eq;
    logic [2:0]         entry_off;
    logic [2:0][TB:0]   tsum_w;
    logic [2:0][TB-1:0] tsum;
    logic               end_hit;

    vrts_axis_sel #(.TB(TB)) u_axis_sel (
        .tnext (tnext_reg),
        .axis  (axis)
    );

    // per-axis step, bounds and saturating add
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lim[i] = (UW'(grid[i]) < SPAN) ? UW'(grid[i]) : SPAN;
            pos_stp[i] = pos_reg[i];
            off[i] = 1'b0;
            if (axis == axis_t'(2'(i)))
            begin
                if (signs_reg[i])
                begin
                    if (pos_reg[i] == '0)
                        off[i] = 1'b1;
                    else
                        pos_stp[i] = pos_reg[i] - PW'(1);
                end
                else
                begin
                    pos_stp[i] = pos_reg[i] + PW'(1);
                    off[i] = UW'(pos_stp[i]) >= lim[i];
                end
            end
            end_eq[i] = pos_stp[i] == PW'(end_reg[i]);
            entry_off[i] = UW'(cell_in[i]) >= lim[i];
            tsum_w[i] = {1'b0, tnext_reg[i]} + {1'b0, tstep_reg[i]};
            tsum[i] = tsum_w[i][TB] ? '1 : tsum_w[i][TB-1:0];
        end
        end_hit = end_en_reg && (&end_eq);
    end

    always_comb
    begin
        pos_next    = pos_reg;
        tnext_next  = tnext_reg;
        tstep_next  = tstep_reg;
        signs_next  = signs_reg;
        end_next    = end_reg;
        end_en_next = end_en_reg;
        active_next = active_reg;
        res_cell    = '0;
        res_flags   = '0;
        case (action_t'(act))
            ACT_SET_END:
            begin
                end_next = cell_in;
            end
            ACT_START:
            begin
                if (|entry_off)
                begin
                    active_next = 1'b0;
                    res_flags.ray_done = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        pos_next[i] = PW'(cell_in[i]);
                    signs_next  = signs_in;
                    tnext_next  = tmax;
                    tstep_next  = tdelta;
                    end_en_next = use_end;
                    active_next = 1'b1;
                    if (keep_first)
                    begin
                        res_cell = cell_in;
                        res_flags.cell_valid = 1'b1;
                    end
                end
            end
            ACT_STEP:
            begin
                if (!active_reg)
                    res_flags.ray_done = 1'b1;
                else
                begin
                    // position keeps the stepped value even when the ray ends
                    pos_next = pos_stp;
                    if ((|off) || end_hit)
                    begin
                        active_next = 1'b0;
                        res_flags.ray_done = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            res_cell[i] = pos_stp[i][CB-1:0];
                            if (axis == axis_t'(2'(i)))
                                tnext_next[i] = tsum[i];
                        end
                        res_flags.cell_valid = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            tnext_reg  <= '0;
            tstep_reg  <= '0;
            signs_reg  <= '0;
            end_reg    <= '0;
            end_en_reg <= 1'b0;
            active_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg    <= pos_next;
            tnext_reg  <= tnext_next;
            tstep_reg  <= tstep_next;
            signs_reg  <= signs_next;
            end_reg    <= end_next;
            end_en_reg <= end_en_next;
            active_reg <= active_next;
        end
    end

endmodule

@@ rtl/vrts_out_reg.sv @@
// result register on the master side of the stream
module vrts_out_reg #(
    parameter int CB = 10,
    parameter int OW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [2:0][CB-1:0]   res_cell,
    input  vrts_pkg::res_flags_t res_flags,
    output logic                 ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OW-1:0]        m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);
    import vrts_pkg::*;

    logic               vld_reg;
    logic [2:0][CB-1:0] cell_reg;
    res_flags_t         flags_reg;

    assign ready    = !vld_reg || m_tready;
    assign m_tvalid = vld_reg;
    assign m_tdata  = OW'(cell_reg);
    assign m_tuser  = flags_reg.cell_valid;
    assign m_tlast  = flags_reg.ray_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (ready)
            vld_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cell_reg  <= res_cell;
            flags_reg <= res_flags;
        end
    end

endmodule

@@ rtl/voxel_ray_traversal_step_unit.sv @@
// 3d grid dda stepper: one action per item, one result item per action
// an accepted item passes through the input register and then the result register
// throughput: one item per cycle unless m_tready stalls the result register; the step loop
// closes through one compare stage and one saturating add from the core state registers back to them
// reset: no ray loaded, end cell zero, grid sizes 1024, keep_first set
module voxel_ray_traversal_step_unit #(
    parameter int COORD_BITS = 10,
    parameter int T_BITS     = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [vrts_pkg::CFG_IDX_BITS-1:0]    cfg_addr,
    input  logic [vrts_pkg::GRID_BITS-1:0]       cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // cell_x, cell_y, cell_z, step_signs, tmax_x, tmax_y, tmax_z,
    // tdelta_x, tdelta_y, tdelta_z, use_end, zero pad
    input  logic [((3*COORD_BITS+4+6*T_BITS+7)/8)*8-1:0] s_tdata,
    input  logic [1:0]                           s_tuser,   // action
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_x, out_y, out_z, zero pad
    output logic [((3*COORD_BITS+7)/8)*8-1:0]    m_tdata,
    output logic                                 m_tuser,   // cell_valid
    output logic                                 m_tlast    // ray_done
);
    import vrts_pkg::*;

    localparam int IW      = ((3*COORD_BITS + 4 + 6*T_BITS + 7) / 8) * 8;
    localparam int OW      = ((3*COORD_BITS + 7) / 8) * 8;
    localparam int SGN_LO  = 3*COORD_BITS;
    localparam int TMAX_LO = SGN_LO + 3;
    localparam int TDEL_LO = TMAX_LO + 3*T_BITS;
    localparam int USE_POS = TDEL_LO + 3*T_BITS;

    logic                           in_vld_reg;
    logic [IW-1:0]                  in_data_reg;
    logic [1:0]                     in_user_reg;
    logic [2:0][GRID_BITS-1:0]      grid_reg;
    logic                           keep_first_reg;
    logic                           out_ready;
    logic                           fire;
    logic [2:0][COORD_BITS-1:0]     cell_in;
    logic [2:0][T_BITS-1:0]         tmax;
    logic [2:0][T_BITS-1:0]         tdelta;
    logic [2:0][COORD_BITS-1:0]     res_cell;
    res_flags_t                     res_flags;

    assign fire     = in_vld_reg && out_ready;
    assign s_tready = !in_vld_reg || out_ready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cell_in[i] = in_data_reg[i*COORD_BITS +: COORD_BITS];
            tmax[i]    = in_data_reg[TMAX_LO + i*T_BITS +: T_BITS];
            tdelta[i]  = in_data_reg[TDEL_LO + i*T_BITS +: T_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg       <= {3{GRID_RESET}};
            keep_first_reg <= 1'b1;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_GRID_X:     grid_reg[0]    <= cfg_wdata;
                CFG_GRID_Y:     grid_reg[1]    <= cfg_wdata;
                CFG_GRID_Z:     grid_reg[2]    <= cfg_wdata;
                CFG_KEEP_FIRST: keep_first_reg <= cfg_wdata[0];
                default:        keep_first_reg <= keep_first_reg;
            endcase
        end
    end

    vrts_core #(
        .CB (COORD_BITS),
        .TB (T_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .act        (in_user_reg),
        .cell_in    (cell_in),
        .signs_in   (in_data_reg[SGN_LO +: 3]),
        .tmax       (tmax),
        .tdelta     (tdelta),
        .use_end    (in_data_reg[USE_POS]),
        .grid       (grid_reg),
        .keep_first (keep_first_reg),
        .res_cell   (res_cell),
        .res_flags  (res_flags)
    );

    vrts_out_reg #(
        .CB (COORD_BITS),
        .OW (OW)
    ) u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res_cell  (res_cell),
        .res_flags (res_flags),
        .ready     (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ tb/sv/voxel_ray_traversal_step_unit_test.sv @@
// testbench for the voxel ray traversal step unit: directed and random rays with a cell predictor
module voxel_ray_traversal_step_unit_test;
    import vrts_pkg::*;

    localparam int IN_W = ((3*10 + 4 + 6*32 + 7) / 8) * 8;
    localparam int OUT_W = ((3*10 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [31:0] T_INF = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0] action;
        logic [9:0] cx;
        logic [9:0] cy;
        logic [9:0] cz;
        logic [2:0] signs;
        logic [2:0][31:0] tmax;    // [0] x, [1] y, [2] z
        logic [2:0][31:0] tdelta;
        logic use_end;
    } ray_cmd_t;

    typedef struct packed {
        logic [9:0] x;
        logic [9:0] y;
        logic [9:0] z;
        logic cell_valid;
        logic ray_done;
    } visit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wen = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_addr = '0;
    logic [GRID_BITS-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // cell_x, cell_y, cell_z, step_signs, tmax_x, tmax_y, tmax_z,
    // tdelta_x, tdelta_y, tdelta_z, use_end, zero pad
    logic [IN_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;   // action
    logic m_tvalid;
    logic m_tready = 1'b0;
    // out_x, out_y, out_z, zero pad
    logic [OUT_W-1:0] m_tdata;
    logic m_tuser;              // cell_valid
    logic m_tlast;              // ray_done

    // predictor state
    logic [2:0][10:0] grid_sz = {3{GRID_RESET}};
    logic keep_first = 1'b1;
    logic [2:0][10:0] pos = '0;
    logic [2:0][31:0] tnext = '0;
    logic [2:0][31:0] tstep = '0;
    logic [2:0] ray_signs = '0;
    logic [2:0][9:0] end_cell = '0;
    logic end_on = 1'b0;
    logic ray_on = 1'b0;

    visit_t pending_cells [$];
    visit_t seen_cell;
    visit_t want_cell;
    int mismatch_count = 0;
    int cmds_sent = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    voxel_ray_traversal_step_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wen(cfg_wen),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [10:0] usable(input logic [10:0] size);
        return (size < 11'd1024) ? size : 11'd1024;
    endfunction

    function automatic logic [31:0] pick_t();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 7);
            1: return $urandom;
            2: return T_INF;
            3: return $urandom_range(0, 32'h0004_0000);
            4: return 32'hFFFF_FF00 | $urandom_range(0, 255);
            default: return 32'h0;
        endcase
    endfunction

    // works out the result item for one command and advances the ray state
    function automatic visit_t trace_cell(input ray_cmd_t c);
        visit_t v;
        int ax;
        logic outside;
        logic [32:0] sum;
        v = '0;
        case (c.action)
            ACT_SET_END:
            begin
                end_cell = {c.cz, c.cy, c.cx};
            end
            ACT_START:
            begin
                if (c.cx >= usable(grid_sz[0]) || c.cy >= usable(grid_sz[1]) ||
                    c.cz >= usable(grid_sz[2]))
                begin
                    ray_on = 1'b0;
                    v.ray_done = 1'b1;
                end
                else
                begin
                    pos = {{1'b0, c.cz}, {1'b0, c.cy}, {1'b0, c.cx}};
                    ray_signs = c.signs;
                    tnext = c.tmax;
                    tstep = c.tdelta;
                    end_on = c.use_end;
                    ray_on = 1'b1;
                    if (keep_first)
                    begin
                        v.x = c.cx;
                        v.y = c.cy;
                        v.z = c.cz;
                        v.cell_valid = 1'b1;
                    end
                end
            end
            ACT_STEP:
            begin
                if (!ray_on)
                begin
                    v.ray_done = 1'b1;
                end
                else
                begin
                    // smallest parameter wins; ties fall to z unless y is strictly below z
                    if (tnext[0] < tnext[1] && tnext[0] < tnext[2])
                        ax = AXIS_X;
                    else if (!(tnext[0] < tnext[1]) && tnext[1] < tnext[2])
                        ax = AXIS_Y;
                    else
                        ax = AXIS_Z;
                    if (ray_signs[ax])
                    begin
                        outside = (pos[ax] == 11'd0);
                        if (!outside)
                            pos[ax] = pos[ax] - 11'd1;
                    end
                    else
                    begin
                        pos[ax] = pos[ax] + 11'd1;
                        outside = (pos[ax] >= usable(grid_sz[ax]));
                    end
                    if (outside || (end_on && pos[0] == {1'b0, end_cell[0]} &&
                                    pos[1] == {1'b0, end_cell[1]} &&
                                    pos[2] == {1'b0, end_cell[2]}))
                    begin
                        ray_on = 1'b0;
                        v.ray_done = 1'b1;
                    end
                    else
                    begin
                        v.x = pos[0][9:0];
                        v.y = pos[1][9:0];
                        v.z = pos[2][9:0];
                        v.cell_valid = 1'b1;
                        sum = {1'b0, tnext[ax]} + {1'b0, tstep[ax]};
                        tnext[ax] = sum[32] ? T_INF : sum[31:0];
                    end
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic void flag_error(input string what, input visit_t want,
                                       input visit_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected x=%0d y=%0d z=%0d valid=%0b done=%0b, %s",
                     what, want.x, want.y, want.z, want.cell_valid, want.ray_done,
                     $sformatf("got x=%0d y=%0d z=%0d valid=%0b done=%0b",
                               got.x, got.y, got.z, got.cell_valid, got.ray_done));
    endfunction

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_cell = {m_tdata[9:0], m_tdata[19:10], m_tdata[29:20], m_tuser, m_tlast};
            if (pending_cells.size() == 0)
            begin
                flag_error("result item with nothing expected", '0, seen_cell);
            end
            else
            begin
                want_cell = pending_cells.pop_front();
                if (seen_cell !== want_cell)
                    flag_error("cell mismatch", want_cell, seen_cell);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_item(input ray_cmd_t c);
        s_tvalid <= 1'b1;
        s_tuser <= c.action;
        s_tdata <= {6'b0, c.use_end, c.tdelta[2], c.tdelta[1], c.tdelta[0],
                    c.tmax[2], c.tmax[1], c.tmax[0], c.signs, c.cz, c.cy, c.cx};
        do @(posedge clk); while (!s_tready);
        pending_cells.push_back(trace_cell(c));
        if (c.action != ACT_UNUSED)
            cmds_sent++;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
    endtask

    // unused fields carry random noise that the block must ignore
    function automatic ray_cmd_t noise_cmd(input logic [1:0] action);
        ray_cmd_t c;
        c.action = action;
        c.cx = 10'($urandom);
        c.cy = 10'($urandom);
        c.cz = 10'($urandom);
        c.signs = 3'($urandom);
        c.tmax = {$urandom, $urandom, $urandom};
        c.tdelta = {$urandom, $urandom, $urandom};
        c.use_end = 1'($urandom);
        return c;
    endfunction

    task automatic send_set_end(input logic [9:0] x, y, z);
        ray_cmd_t c;
        c = noise_cmd(ACT_SET_END);
        c.cx = x;
        c.cy = y;
        c.cz = z;
        send_item(c);
    endtask

    task automatic send_start(input logic [9:0] x, y, z, input logic [2:0] sg,
                              input logic [2:0][31:0] tmx, tdl, input logic ue);
        ray_cmd_t c;
        c = noise_cmd(ACT_START);
        c.cx = x;
        c.cy = y;
        c.cz = z;
        c.signs = sg;
        c.tmax = tmx;
        c.tdelta = tdl;
        c.use_end = ue;
        send_item(c);
    endtask

    task automatic send_step();
        send_item(noise_cmd(ACT_STEP));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input logic [10:0] gx, gy, gz, input logic kf);
        cfg_wen <= 1'b1;
        cfg_addr <= CFG_GRID_X;
        cfg_wdata <= gx;
        @(posedge clk);
        cfg_addr <= CFG_GRID_Y;
        cfg_wdata <= gy;
        @(posedge clk);
        cfg_addr <= CFG_GRID_Z;
        cfg_wdata <= gz;
        @(posedge clk);
        cfg_addr <= CFG_KEEP_FIRST;
        cfg_wdata <= {10'b0, kf};
        @(posedge clk);
        cfg_wen <= 1'b0;
        grid_sz = {gz, gy, gx};
        keep_first = kf;
    endtask

    // tmax and tdelta vectors below are written {z, y, x}
    task automatic test_stepping_basics();
        send_step();                        // no ray loaded yet
        send_item(noise_cmd(ACT_UNUSED));
        send_set_end(10'd2, 10'd0, 10'd0);
        send_start(10'd0, 10'd0, 10'd0, 3'b000, {T_INF, T_INF, 32'd0},
                   {32'd1, 32'd1, 32'd1}, 1'b1);
        send_step();
        send_step();                        // lands on the end cell
        send_step();
        send_start(10'd1023, 10'd1023, 10'd1023, 3'b000, {32'd5, 32'd5, 32'd0},
                   {T_INF, T_INF, T_INF}, 1'b0);
        send_step();                        // leaves through the top
        send_start(10'd0, 10'd0, 10'd0, 3'b111, {T_INF, T_INF, T_INF},
                   {T_INF, T_INF, T_INF}, 1'b0);
        send_step();                        // full tie picks z, leaves below zero
        send_start(10'd500, 10'd500, 10'd500, 3'b010, {T_INF, 32'hFFFF_FFF0, T_INF},
                   {T_INF, T_INF, T_INF}, 1'b0);
        send_step();                        // y saturates here
        send_step();
        send_set_end(10'd1023, 10'd1023, 10'd1023);
        send_set_end(10'd7, 10'd8, 10'd9);
        send_start(10'd7, 10'd8, 10'd9, 3'b101, {32'd9, 32'd4, 32'd4},
                   {32'd3, 32'd3, 32'd3}, 1'b1);
        send_step();
        send_step();
        send_step();
    endtask

    task automatic test_grid_limits();
        wait_drained();
        apply_config(11'd3, 11'd1, 11'd2047, 1'b0);
        send_start(10'd3, 10'd0, 10'd0, 3'b000, '0, '0, 1'b0);
        send_start(10'd0, 10'd1, 10'd0, 3'b000, '0, '0, 1'b0);
        send_start(10'd2, 10'd0, 10'd1023, 3'b000, {32'd0, T_INF, T_INF},
                   {32'd1, 32'd1, 32'd1}, 1'b0);
        send_step();                        // z capped at the coordinate range
        send_start(10'd2, 10'd0, 10'd5, 3'b000, {32'd9, 32'd1, 32'd9}, '0, 1'b0);
        send_step();
        send_start(10'd2, 10'd0, 10'd5, 3'b000, {32'd9, 32'd9, 32'd1}, '0, 1'b0);
        send_step();
        wait_drained();
        apply_config(11'd0, 11'd1024, 11'd1024, 1'b1);
        send_start(10'd0, 10'd0, 10'd0, 3'b000, '0, '0, 1'b0);
        send_step();
    endtask

    function automatic logic [10:0] pick_grid();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 11'd1;
        if (r == 1)
            return 11'd1024;
        if (r < 8)
            return 11'($urandom_range(2, 12));
        return 11'($urandom_range(13, 200));
    endfunction

    // optional end cell, start and a run of steps, with random content
    task automatic run_ray();
        logic [2:0][9:0] entry;
        logic [2:0][9:0] endc;
        logic [2:0][31:0] tmx;
        logic [2:0][31:0] tdl;
        logic [2:0] sg;
        logic ue;
        logic aligned;
        int lim;
        int ax_only;
        int e;
        int i;
        sg = 3'($urandom);
        ue = 1'($urandom_range(0, 1));
        aligned = ($urandom_range(0, 99) < 35);
        ax_only = $urandom_range(0, 2);
        for (i = 0; i < 3; i++)
        begin
            lim = int'(usable(grid_sz[i]));
            if (lim == 0)
                entry[i] = 10'($urandom);
            else if ($urandom_range(0, 4) == 0)
                entry[i] = $urandom_range(0, 1) ? 10'(lim - 1) : 10'd0;
            else
                entry[i] = 10'($urandom_range(0, lim - 1));
            e = int'(entry[i]);
            if (!aligned || i == ax_only)
                e = sg[i] ? e - int'($urandom_range(0, 3)) : e + int'($urandom_range(0, 3));
            if (e < 0)
                e = 0;
            if (e > 1023)
                e = 1023;
            endc[i] = 10'(e);
            tmx[i] = (aligned && i != ax_only) ? T_INF : pick_t();
            tdl[i] = pick_t();
        end
        if (aligned)
            tmx[ax_only] = $urandom_range(0, 1000);
        if (ue || $urandom_range(0, 3) == 0)
            send_set_end(endc[0], endc[1], endc[2]);
        send_start(entry[0], entry[1], entry[2], sg, tmx, tdl, ue);
        repeat ($urandom_range(1, 24))
            send_step();
    endtask

    task automatic test_random_rays(input int n_items, input int src_pct, input int sink_pct);
        int first;
        int next_cfg;
        int lim;
        int ax;
        logic [2:0][9:0] entry;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        first = cmds_sent;
        next_cfg = 0;
        while (cmds_sent - first < n_items)
        begin
            if (cmds_sent - first >= next_cfg)
            begin
                // sender holds off until every result has come back
                wait_drained();
                apply_config(pick_grid(), pick_grid(), pick_grid(),
                             1'($urandom_range(0, 1)));
                next_cfg = cmds_sent - first + $urandom_range(100, 160);
            end
            if ($urandom_range(0, 99) >= 8)
            begin
                run_ray();
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: send_step();
                    1: send_set_end(10'($urandom), 10'($urandom), 10'($urandom));
                    2: send_item(noise_cmd(ACT_UNUSED));
                    default:
                    begin
                        // entry at or past the grid edge on one axis, where the grid is below the coordinate range
                        ax = $urandom_range(0, 2);
                        lim = int'(usable(grid_sz[ax]));
                        entry = {10'($urandom_range(0, 7)), 10'($urandom_range(0, 7)),
                                 10'($urandom_range(0, 7))};
                        if (lim < 1024)
                            entry[ax] = 10'($urandom_range(lim, 1023));
                        send_start(entry[0], entry[1], entry[2], 3'($urandom),
                                   {pick_t(), pick_t(), pick_t()},
                                   {pick_t(), pick_t(), pick_t()}, 1'b0);
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stepping_basics();
        test_grid_limits();
        test_random_rays(475, 0, 0);
        test_random_rays(475, 55, 0);
        test_random_rays(475, 0, 55);
        test_random_rays(475, 20, 20);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_cells.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
